// ----- design/pba_pkg.sv -----
`default_nettype none
package pba_pkg;

  localparam int CNT_W  = 9;
  localparam int IDX_W  = 8;
  localparam int BYTE_W = 33;
  localparam int TOT_W  = 48;

  localparam logic [BYTE_W-1:0] DEFAULT_PAGE_BYTES = 33'd4194304;
  localparam logic [BYTE_W-1:0] ALIGN_MASK         = 33'd15;

  localparam logic OP_STAGE = 1'b0;
  localparam logic OP_RESET = 1'b1;

  localparam logic [1:0] ST_PLACED  = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_NO_ROOM = 2'd2;
  localparam logic [1:0] ST_RESET   = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              vld;
    logic              done;
    logic [BYTE_W-1:0] aligned;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] offset;
    logic              opened;
  } token_t;

  typedef struct packed {
    logic              clr;
    logic [CNT_W-1:0]  scan;
    logic [CNT_W-1:0]  open_cnt;
    logic [BYTE_W-1:0] base;
  } bcast_t;

endpackage
`default_nettype wire

// ----- design/pba_cell.sv -----
`default_nettype none
module pba_cell #(
  parameter int IDX = 0
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire pba_pkg::bcast_t bc,
  input  wire pba_pkg::token_t tok_i,
  output pba_pkg::token_t      tok_o
);

  localparam logic [pba_pkg::CNT_W-1:0] IDX_C = pba_pkg::CNT_W'(IDX);

  logic [pba_pkg::BYTE_W-1:0] cap_r, cap_nxt;
  logic [pba_pkg::BYTE_W-1:0] fill_r, fill_nxt;
  logic [pba_pkg::BYTE_W-1:0] room;
  pba_pkg::token_t            tok_r, tok_nxt;
  logic                       here, fits;

  always_comb begin
    cap_nxt  = cap_r;
    fill_nxt = fill_r;
    tok_nxt  = tok_i;
    room     = (fill_r > cap_r) ? '0 : cap_r - fill_r;
    here     = tok_i.vld && !tok_i.done;
    fits     = (IDX_C >= bc.scan) && (IDX_C < bc.open_cnt) && (room >= tok_i.aligned);
    if (bc.clr) begin
      fill_nxt = '0;
    end else if (here && fits) begin
      fill_nxt       = fill_r + tok_i.aligned;
      tok_nxt.done   = 1'b1;
      tok_nxt.idx    = pba_pkg::IDX_W'(IDX);
      tok_nxt.offset = fill_r;
      tok_nxt.opened = 1'b0;
    end else if (here && (IDX_C == bc.open_cnt)) begin
      // open this page
      cap_nxt        = (bc.base > tok_i.aligned) ? bc.base : tok_i.aligned;
      fill_nxt       = tok_i.aligned;
      tok_nxt.done   = 1'b1;
      tok_nxt.idx    = pba_pkg::IDX_W'(IDX);
      tok_nxt.offset = '0;
      tok_nxt.opened = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cap_r  <= cap_nxt;
    fill_r <= fill_nxt;
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule
`default_nettype wire

// ----- design/paged_bump_allocator.sv -----
`default_nettype none
// channel | direction | handshake             | payload
// in_     | input     | in_valid / in_ready   | in_operation, in_request_bytes
// out_    | output    | out_valid / out_ready | out_status, out_page_index, out_page_offset,
//         |           |                       | out_opened_page, out_total_bytes
// cfg_    | input     | cfg_valid / cfg_ready | cfg_data (page_size)
//
// a stage item with nonzero size walks the row of page cells, one cell a cycle;
// its result then goes from the last cell through the result registers and the done state
// into the output register, and only then is the next item taken. zero size and page reset
// items skip the walk and go straight to the done state. one item is in work at a time.
// reset (rst_n low, synchronous) empties the table and sets page_size to 4 MiB.
// a held result in the output register does not block accepting the next item;
// a finished item waits there until out_ready.
module paged_bump_allocator #(
  parameter int MAX_PAGES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_operation,
  input  wire logic [31:0] in_request_bytes,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [3:0]       out_page_index,
  output logic [32:0]      out_page_offset,
  output logic             out_opened_page,
  output logic [47:0]      out_total_bytes,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  localparam int CW = pba_pkg::CNT_W;
  localparam int BW = pba_pkg::BYTE_W;
  localparam int TW = pba_pkg::TOT_W;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_PAGES);

  pba_pkg::state_t state_r, state_nxt;
  pba_pkg::token_t tok [MAX_PAGES+1];
  pba_pkg::bcast_t bc;

  logic [31:0]            page_size_r;
  logic [CW-1:0]          open_r, open_nxt;
  logic [CW-1:0]          scan_r, scan_nxt;
  logic [TW-1:0]          total_r, total_nxt;
  logic [31:0]            size_r, size_nxt;
  logic [1:0]             res_st_r, res_st_nxt;
  logic [pba_pkg::IDX_W-1:0] res_idx_r, res_idx_nxt;
  logic [BW-1:0]          res_off_r, res_off_nxt;
  logic                   res_open_r, res_open_nxt;
  logic                   out_vld_r, out_vld_nxt;
  logic [1:0]             o_st_r, o_st_nxt;
  logic [3:0]             o_idx_r, o_idx_nxt;
  logic [BW-1:0]          o_off_r, o_off_nxt;
  logic                   o_open_r, o_open_nxt;
  logic [TW-1:0]          o_tot_r, o_tot_nxt;
  logic [TW:0]            sum;
  logic                   acc;
  pba_pkg::token_t        inj;
  pba_pkg::token_t        tail;

  assign in_ready  = (state_r == pba_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign acc       = in_valid && in_ready;
  assign tail      = tok[MAX_PAGES];

  assign bc.scan     = scan_r;
  assign bc.open_cnt = open_r;
  assign bc.base     = (page_size_r == 32'd0) ? pba_pkg::DEFAULT_PAGE_BYTES
                                              : {1'b0, page_size_r};
  assign bc.clr      = acc && (in_operation == pba_pkg::OP_RESET);

  always_comb begin
    inj         = '0;
    inj.vld     = acc && (in_operation == pba_pkg::OP_STAGE) && (in_request_bytes != 32'd0);
    inj.aligned = ({1'b0, in_request_bytes} + pba_pkg::ALIGN_MASK) & ~pba_pkg::ALIGN_MASK;
  end

  assign tok[0] = inj;

  for (genvar g = 0; g < MAX_PAGES; g++) begin : g_cell
    pba_cell #(.IDX(g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .bc    (bc),
      .tok_i (tok[g]),
      .tok_o (tok[g+1])
    );
  end

  always_comb begin
    state_nxt    = state_r;
    open_nxt     = open_r;
    scan_nxt     = scan_r;
    total_nxt    = total_r;
    size_nxt     = size_r;
    res_st_nxt   = res_st_r;
    res_idx_nxt  = res_idx_r;
    res_off_nxt  = res_off_r;
    res_open_nxt = res_open_r;
    out_vld_nxt  = out_vld_r && !out_ready;
    o_st_nxt     = o_st_r;
    o_idx_nxt    = o_idx_r;
    o_off_nxt    = o_off_r;
    o_open_nxt   = o_open_r;
    o_tot_nxt    = o_tot_r;
    sum          = {1'b0, total_r} + {{(TW-31){1'b0}}, size_r};
    case (state_r)
      pba_pkg::S_IDLE: begin
        if (acc) begin
          size_nxt     = in_request_bytes;
          res_idx_nxt  = '0;
          res_off_nxt  = '0;
          res_open_nxt = 1'b0;
          if (in_operation == pba_pkg::OP_RESET) begin
            scan_nxt   = '0;
            total_nxt  = '0;
            res_st_nxt = pba_pkg::ST_RESET;
            state_nxt  = pba_pkg::S_DONE;
          end else if (in_request_bytes == 32'd0) begin
            res_st_nxt = pba_pkg::ST_ZERO;
            state_nxt  = pba_pkg::S_DONE;
          end else begin
            state_nxt = pba_pkg::S_SCAN;
          end
        end
      end
      pba_pkg::S_SCAN: begin
        if (tail.vld) begin
          state_nxt = pba_pkg::S_DONE;
          if (tail.done) begin
            res_st_nxt   = pba_pkg::ST_PLACED;
            res_idx_nxt  = tail.idx;
            res_off_nxt  = tail.offset;
            res_open_nxt = tail.opened;
            scan_nxt     = CW'(tail.idx);
            if (tail.opened && (open_r < MAX_C)) begin
              open_nxt = open_r + CW'(1);
            end
            total_nxt = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
          end else begin
            res_st_nxt = pba_pkg::ST_NO_ROOM;
          end
        end
      end
      pba_pkg::S_DONE: begin
        if (!out_vld_r || out_ready) begin
          out_vld_nxt = 1'b1;
          o_st_nxt    = res_st_r;
          o_idx_nxt   = res_idx_r[3:0];
          o_off_nxt   = res_off_r;
          o_open_nxt  = res_open_r;
          o_tot_nxt   = total_r;
          state_nxt   = pba_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pba_pkg::S_IDLE;
      open_r      <= '0;
      scan_r      <= '0;
      total_r     <= '0;
      out_vld_r   <= 1'b0;
      page_size_r <= 32'd4194304;
    end else begin
      state_r   <= state_nxt;
      open_r    <= open_nxt;
      scan_r    <= scan_nxt;
      total_r   <= total_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        page_size_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    size_r     <= size_nxt;
    res_st_r   <= res_st_nxt;
    res_idx_r  <= res_idx_nxt;
    res_off_r  <= res_off_nxt;
    res_open_r <= res_open_nxt;
    o_st_r     <= o_st_nxt;
    o_idx_r    <= o_idx_nxt;
    o_off_r    <= o_off_nxt;
    o_open_r   <= o_open_nxt;
    o_tot_r    <= o_tot_nxt;
  end

  assign out_valid       = out_vld_r;
  assign out_status      = o_st_r;
  assign out_page_index  = o_idx_r;
  assign out_page_offset = o_off_r;
  assign out_opened_page = o_open_r;
  assign out_total_bytes = o_tot_r;

endmodule
`default_nettype wire
